// ----- rtl/prince_block_encrypt_unit_defines.svh -----
// Assertion macros shared by the checker of the PRINCE encryption unit.
// Depends on nothing; the using module must provide clk and rst.
`ifndef PRINCE_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define PRINCE_BLOCK_ENCRYPT_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is active.
`define PRINCE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is active.
`define PRINCE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define PRINCE_ASSERT_RST(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/prince_pkg.sv -----
// Constants, tables and layer functions of the PRINCE cipher.
// Used by the pipeline top level; depends on nothing.
package prince_pkg;

  localparam int BLOCK_W    = 64;
  localparam int NUM_STAGES = 12;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WHITENING_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_KEY      = 1'b1;

  localparam logic [BLOCK_W-1:0] ROUND_CONST [12] = '{
    64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
    64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
    64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa, 64'hc882d32f25323c54,
    64'h64a51195e0e3610d, 64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
  };

  localparam logic [3:0] FWD_SBOX [16] = '{
    4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
    4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4
  };

  localparam logic [3:0] INV_SBOX [16] = '{
    4'hB, 4'h7, 4'h3, 4'h2, 4'hF, 4'hD, 4'h8, 4'h9,
    4'hA, 4'h6, 4'h4, 4'h0, 4'h5, 4'hE, 4'hC, 4'h1
  };

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    for (int m = 0; m < 16; m++) begin
      r[4*m +: 4] = FWD_SBOX[x[4*m +: 4]];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    for (int m = 0; m < 16; m++) begin
      r[4*m +: 4] = INV_SBOX[x[4*m +: 4]];
    end
    return r;
  endfunction

  // Nibble 0 is the most significant nibble.
  function automatic logic [BLOCK_W-1:0] shift_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    int                 j;
    for (int i = 0; i < 16; i++) begin
      j = (5 * i) & 15;
      r[63-4*i -: 4] = x[63-4*j -: 4];
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] shift_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    int                 j;
    for (int i = 0; i < 16; i++) begin
      j = (5 * i) & 15;
      r[63-4*j -: 4] = x[63-4*i -: 4];
    end
    return r;
  endfunction

  // Block-diagonal involution M' = diag(M0hat, M1hat, M1hat, M0hat).
  function automatic logic [BLOCK_W-1:0] mix(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    logic               acc;
    int                 off;
    int                 brow;
    int                 b;
    for (int q = 0; q < 4; q++) begin
      off = (q == 0 || q == 3) ? 0 : 1;
      for (int row = 0; row < 16; row++) begin
        brow = row >> 2;
        b    = row & 3;
        acc  = 1'b0;
        for (int col = 0; col < 4; col++) begin
          if (((brow + col + off) & 3) != b) begin
            acc = acc ^ x[63 - (16*q + 4*col + b)];
          end
        end
        r[63 - (16*q + row)] = acc;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/prince_pipe_stage.sv -----
// One register stage of the PRINCE pipeline: data register, valid bit and
// bubble-collapsing ready. Depends on nothing but its ports.
module prince_pipe_stage #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  logic             down_ready,
  input  logic [WIDTH-1:0] data_next,
  output logic             valid,
  output logic             ready,
  output logic [WIDTH-1:0] data
);

  assign ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      data <= data_next;
    end
  end

endmodule

// ----- rtl/prince_block_encrypt_unit.sv -----
// Channel   | Signals                                       | Direction
// ----------+-----------------------------------------------+----------
// input     | in_valid, in_stall, plaintext[63:0]           | in
// output    | out_valid, out_stall, ciphertext[63:0]        | out
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data     | in
//
// Twelve register stages: whitening, 5 forward, middle, 5 inverse.
// One transaction is accepted every cycle while the output is taken.
// A stalled output holds; empty stages upstream still fill.
// Synchronous reset clears the valid bits and both key registers.
// Depends on prince_pkg and prince_pipe_stage.
module prince_block_encrypt_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [prince_pkg::BLOCK_W-1:0]   plaintext,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [prince_pkg::BLOCK_W-1:0]   ciphertext,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prince_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prince_pkg::BLOCK_W-1:0]   cfg_data
);

  localparam int WIDTH = prince_pkg::BLOCK_W;
  localparam int N     = prince_pkg::NUM_STAGES;

  logic [WIDTH-1:0] whitening_key;
  logic [WIDTH-1:0] core_key;
  logic [WIDTH-1:0] k0_out;

  logic [N-1:0]     stage_valid;
  logic [N-1:0]     stage_ready;
  logic [WIDTH-1:0] stage_data [N];
  logic [WIDTH-1:0] stage_next [N];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      whitening_key <= '0;
      core_key      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prince_pkg::REG_WHITENING_KEY: whitening_key <= cfg_data;
        prince_pkg::REG_CORE_KEY:      core_key      <= cfg_data;
      endcase
    end
  end

  assign k0_out = {whitening_key[0], whitening_key[WIDTH-1:1]}
                ^ {{(WIDTH-1){1'b0}}, whitening_key[WIDTH-1]};

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic up_valid;
    logic down_ready;

    if (g == 0) begin : g_white
      assign up_valid      = in_valid;
      assign stage_next[g] = plaintext ^ whitening_key ^ core_key
                           ^ prince_pkg::ROUND_CONST[0];
    end else if (g <= 5) begin : g_fwd
      assign up_valid      = stage_valid[g-1];
      assign stage_next[g] = prince_pkg::shift_fwd(prince_pkg::mix(
                               prince_pkg::sub_fwd(stage_data[g-1])))
                           ^ core_key ^ prince_pkg::ROUND_CONST[g];
    end else if (g == 6) begin : g_mid
      assign up_valid      = stage_valid[g-1];
      assign stage_next[g] = prince_pkg::sub_inv(prince_pkg::mix(
                               prince_pkg::sub_fwd(stage_data[g-1])));
    end else if (g < N - 1) begin : g_inv
      assign up_valid      = stage_valid[g-1];
      assign stage_next[g] = prince_pkg::sub_inv(prince_pkg::mix(
                               prince_pkg::shift_inv(stage_data[g-1] ^ core_key
                               ^ prince_pkg::ROUND_CONST[g-1])));
    end else begin : g_last
      assign up_valid      = stage_valid[g-1];
      assign stage_next[g] = prince_pkg::sub_inv(prince_pkg::mix(
                               prince_pkg::shift_inv(stage_data[g-1] ^ core_key
                               ^ prince_pkg::ROUND_CONST[g-1])))
                           ^ core_key ^ prince_pkg::ROUND_CONST[g] ^ k0_out;
    end

    if (g == N - 1) begin : g_tail
      assign down_ready = !out_stall;
    end else begin : g_body
      assign down_ready = stage_ready[g+1];
    end

    prince_pipe_stage #(
      .WIDTH(WIDTH)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (up_valid),
      .down_ready(down_ready),
      .data_next (stage_next[g]),
      .valid     (stage_valid[g]),
      .ready     (stage_ready[g]),
      .data      (stage_data[g])
    );
  end

  assign in_stall   = !stage_ready[0];
  assign out_valid  = stage_valid[N-1];
  assign ciphertext = stage_data[N-1];

endmodule

// ----- rtl/prince_checker.sv -----
// Port-level checks for the PRINCE encryption unit, bound to its top level.
// Depends on prince_block_encrypt_unit_defines.svh and prince_pkg.
`include "prince_block_encrypt_unit_defines.svh"

module prince_checker #(
  parameter int WIDTH = prince_pkg::BLOCK_W
) (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] ciphertext,
  input logic             cfg_ready
);

  `PRINCE_ASSERT_RST(a_reset_empty, rst, !out_valid, "output valid right after reset")
  `PRINCE_ASSERT_NOW(a_stall_only_full, in_stall, out_valid && out_stall,
                     "input stalled while the output side is free")
  `PRINCE_ASSERT_NOW(a_cfg_always_ready, 1'b1, cfg_ready, "configuration port not ready")
  `PRINCE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid,
                      "stalled output transaction dropped")
  `PRINCE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(ciphertext),
                      "stalled ciphertext changed")

endmodule

bind prince_block_encrypt_unit prince_checker #(
  .WIDTH(WIDTH)
) u_prince_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .ciphertext(ciphertext),
  .cfg_ready (cfg_ready)
);
